@@ design/tsp_pkg.sv @@
// Package: types and constants shared by the table shuffle generator modules.
package tsp_pkg;
	localparam logic [31:0] HashMulA  = 32'h7feb352d;
	localparam logic [31:0] HashMulB  = 32'h846ca68b;
	localparam logic [31:0] PermMul   = 32'h9e3779b7;
	localparam logic [31:0] MixMul    = 32'h06a0dd9b;
	localparam logic [7:0]  CycleLen  = 8'd255;
	localparam logic        OpSeed    = 1'b0;
	localparam logic        OpGen     = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6,
		ST_FILL_A, ST_FILL_B, ST_FILL_C,
		ST_G_RD, ST_G_M1, ST_G_M2, ST_G_RS, ST_G_WR,
		ST_F_RD, ST_F_WAIT, ST_F_ACC, ST_F_DONE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0] random_word;
		logic [31:0] cycle_constant;
	} result_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] w;
		w = {v, v} << s;
		return w[63:32];
	endfunction
endpackage

@@ design/tsp_if.sv @@
// Valid/ready channel interface carrying a payload word.
interface tsp_if #(parameter int W = 32) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/tsp_mul.sv @@
// Shared registered 32x32 multiplier, low word of the product.
module tsp_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] p
);
	logic [31:0] full;
	assign full = a * b;
	always_ff @(posedge clk) begin
		p <= full;
	end
endmodule

@@ design/table_shuffle_prng_generator.sv @@
// Table shuffle generator: a generate word steps through G_RD, G_M1, G_M2, G_RS and G_WR
// to the output state, then back to idle, where the next word is taken.
// A seed word keeps the block busy through hashing and a fill of every table entry; the last
// word of each 255-word cycle adds a fold over the tables before its result. A result waiting on out_ch
// stalls the next generate word in its output state only; one shared multiplier serves hashing and fill.
// Reset (arst_n low) clears control state; tables are undefined until a seed word.
module table_shuffle_prng_generator #(
	parameter int TABLE_ENTRIES = 256
) (
	input  logic clk,
	input  logic arst_n,
	tsp_if.sink   in_ch,
	tsp_if.source out_ch
);
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int GW = AW - 3;

	tsp_pkg::state_t st_q, st_d;
	logic [31:0] key_q, h_q, cons_q, run_q, o_q, c_q, mv_q, acc_q, res_q, cc_q;
	logic [7:0]  idx_q, d_q;
	logic [AW:0] k_q;
	logic [2:0]  grp_q;
	logic [31:0] perm_mem [TABLE_ENTRIES];
	logic [31:0] mix_mem  [TABLE_ENTRIES];
	logic [31:0] pr0_q, pr1_q, mr0_q, mr1_q;
	logic [AW-1:0] pa0, pa1, ma0, ma1;
	logic        pw0, pw1, mw0;
	logic [31:0] pwd0, pwd1, mwd0;
	logic [31:0] ma, mb, mp;
	logic        out_v_q;
	logic        out_load;
	tsp_pkg::result_t res_o_q;

	tsp_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

	assign in_ch.ready  = (st_q == tsp_pkg::ST_IDLE);
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = res_o_q;
	// output register free or being emptied this cycle
	assign out_load = (st_q == tsp_pkg::ST_OUT) && (!out_v_q || out_ch.ready);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			tsp_pkg::ST_IDLE: if (in_ch.valid && in_ch.ready)
				st_d = (in_ch.data[0] == tsp_pkg::OpSeed) ? tsp_pkg::ST_H1 : tsp_pkg::ST_G_RD;
			tsp_pkg::ST_H1: st_d = tsp_pkg::ST_H2;
			tsp_pkg::ST_H2: st_d = tsp_pkg::ST_H3;
			tsp_pkg::ST_H3: st_d = tsp_pkg::ST_H4;
			tsp_pkg::ST_H4: st_d = tsp_pkg::ST_H5;
			tsp_pkg::ST_H5: st_d = tsp_pkg::ST_H6;
			tsp_pkg::ST_H6: st_d = tsp_pkg::ST_FILL_A;
			tsp_pkg::ST_FILL_A: st_d = tsp_pkg::ST_FILL_B;
			tsp_pkg::ST_FILL_B: st_d = tsp_pkg::ST_FILL_C;
			tsp_pkg::ST_FILL_C:
				st_d = (k_q == (AW+1)'(TABLE_ENTRIES-1)) ? tsp_pkg::ST_IDLE : tsp_pkg::ST_FILL_A;
			tsp_pkg::ST_G_RD: st_d = tsp_pkg::ST_G_M1;
			tsp_pkg::ST_G_M1: st_d = tsp_pkg::ST_G_M2;
			tsp_pkg::ST_G_M2: st_d = tsp_pkg::ST_G_RS;
			tsp_pkg::ST_G_RS: st_d = tsp_pkg::ST_G_WR;
			tsp_pkg::ST_G_WR: st_d = (idx_q <= 8'd1) ? tsp_pkg::ST_F_RD : tsp_pkg::ST_OUT;
			tsp_pkg::ST_F_RD: st_d = tsp_pkg::ST_F_WAIT;
			tsp_pkg::ST_F_WAIT: st_d = tsp_pkg::ST_F_ACC;
			tsp_pkg::ST_F_ACC:
				st_d = (k_q == (AW+1)'(TABLE_ENTRIES-1)) ? tsp_pkg::ST_F_DONE : tsp_pkg::ST_F_RD;
			tsp_pkg::ST_F_DONE: st_d = tsp_pkg::ST_OUT;
			tsp_pkg::ST_OUT: st_d = out_load ? tsp_pkg::ST_IDLE : tsp_pkg::ST_OUT;
			default: st_d = tsp_pkg::ST_IDLE;
		endcase
	end

	// memory ports and multiplier operands
	always_comb begin
		pa0 = k_q[AW-1:0]; pa1 = k_q[AW-1:0]; ma0 = k_q[AW-1:0]; ma1 = k_q[AW-1:0];
		pw0 = 1'b0; pw1 = 1'b0; mw0 = 1'b0;
		pwd0 = mp; pwd1 = pr0_q; mwd0 = mp;
		ma = h_q; mb = tsp_pkg::HashMulA;
		unique case (st_q)
			tsp_pkg::ST_H1: begin ma = key_q ^ (key_q >> 16); mb = tsp_pkg::HashMulA; end
			tsp_pkg::ST_H3: begin ma = h_q; mb = tsp_pkg::HashMulB; end
			tsp_pkg::ST_H5: begin ma = h_q; mb = tsp_pkg::PermMul; end
			tsp_pkg::ST_H6: begin ma = h_q; mb = tsp_pkg::MixMul; end
			tsp_pkg::ST_FILL_A: begin ma = 32'(k_q[AW-1:0]); mb = tsp_pkg::PermMul; end
			tsp_pkg::ST_FILL_B: begin
				ma = 32'(k_q[AW-1:0]); mb = tsp_pkg::MixMul;
				pw0 = 1'b1;
				pwd0 = tsp_pkg::rotl(mp + acc_q, h_q[4:0] ^ 5'(k_q[AW-1:0]));
			end
			tsp_pkg::ST_FILL_C: begin
				mw0 = 1'b1;
				mwd0 = tsp_pkg::rotl(mp + mv_q, h_q[4:0] ^ 5'(k_q[AW-1:0]));
			end
			tsp_pkg::ST_G_RD: begin
				ma0 = AW'(idx_q + 8'd6); ma1 = AW'(idx_q + 8'd7);
			end
			tsp_pkg::ST_G_RS: begin
				pa0 = AW'(idx_q); pa1 = AW'(c_q[7:0]);
			end
			tsp_pkg::ST_G_WR: begin
				pa0 = AW'(idx_q); pa1 = AW'(d_q);
				pw0 = 1'b1; pwd0 = pr1_q;
				pw1 = 1'b1; pwd1 = pr0_q;
			end
			// fold writes mix ^ perm back into the mix table
			tsp_pkg::ST_F_ACC: begin
				mw0 = 1'b1;
				mwd0 = mr0_q ^ pr0_q;
			end
			default: ;
		endcase
	end

	// table RAMs: two ports each, registered read
	always_ff @(posedge clk) begin
		if (pw0) perm_mem[pa0] <= pwd0;
		if (pw1 && !(pw0 && pa0 == pa1)) perm_mem[pa1] <= pwd1;
		if (mw0) mix_mem[ma0] <= mwd0;
		pr0_q <= perm_mem[pa0];
		pr1_q <= perm_mem[pa1];
		mr0_q <= mix_mem[ma0];
		mr1_q <= mix_mem[ma1];
	end

	logic [31:0] run_n, b_n;
	assign run_n = (32'(d_q) ^ o_q) ^ (cons_q + run_q);
	assign b_n   = (cons_q + run_n) ^ (o_q + 32'(d_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= tsp_pkg::ST_IDLE;
			cons_q <= '0; run_q <= '0; d_q <= '0; idx_q <= tsp_pkg::CycleLen;
			k_q <= '0; out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (out_load) out_v_q <= 1'b1;
			else if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			unique case (st_q)
				tsp_pkg::ST_IDLE: begin
					key_q <= in_ch.data[32:1];
					k_q <= '0;
				end
				tsp_pkg::ST_H2: h_q <= mp ^ (mp >> 15);
				tsp_pkg::ST_H4: h_q <= mp ^ (mp >> 16);
				tsp_pkg::ST_H5: begin
					h_q <= h_q;
				end
				tsp_pkg::ST_H6: acc_q <= mp;
				tsp_pkg::ST_FILL_A: if (k_q == '0) mv_q <= mp;
				tsp_pkg::ST_FILL_C: begin
					k_q <= k_q + 1'b1;
					if (k_q == (AW+1)'(TABLE_ENTRIES-1)) begin
						cons_q <= key_q; run_q <= key_q; d_q <= '0;
						idx_q <= tsp_pkg::CycleLen;
					end
				end
				tsp_pkg::ST_G_M1: o_q <= (mr0_q << 6) ^ (mr1_q << 7);
				tsp_pkg::ST_G_M2: begin
					run_q <= run_n;
					c_q <= tsp_pkg::rotl((run_n >> 13) ^ run_n, b_n[4:0]);
				end
				tsp_pkg::ST_G_RS: begin
					res_q <= c_q;
					d_q <= c_q[7:0];
				end
				tsp_pkg::ST_G_WR: begin
					cc_q <= cons_q;
					k_q <= '0; acc_q <= '0; grp_q <= '0; mv_q <= '0;
					if (idx_q > 8'd1) idx_q <= idx_q - 8'd1;
				end
				tsp_pkg::ST_F_ACC: begin
					k_q <= k_q + 1'b1;
					if (k_q[GW-1:0] == {GW{1'b1}}) begin
						mv_q <= mv_q ^ ((acc_q ^ mr0_q ^ pr0_q) << grp_q);
						acc_q <= '0;
						grp_q <= grp_q + 3'd1;
					end else begin
						acc_q <= acc_q ^ mr0_q ^ pr0_q;
					end
				end
				tsp_pkg::ST_F_DONE: begin
					cons_q <= mv_q; run_q <= mv_q; d_q <= '0;
					idx_q <= tsp_pkg::CycleLen;
				end
				tsp_pkg::ST_OUT: if (out_load)
					res_o_q <= '{random_word: res_q, cycle_constant: cc_q};
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ch.ready |=> out_v_q) else $error("result dropped");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ch.ready |=> $stable(res_o_q)) else $error("result changed");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != tsp_pkg::ST_IDLE |-> !in_ch.ready) else $error("ready while busy");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 8'd0) else $error("step index zero");
`endif
endmodule

@@ dv/tb_table_shuffle_prng_generator.sv @@
// Testbench for the table shuffle generator: directed and random seed/generate words, self-checked.
`timescale 1ns / 1ps

module tb_table_shuffle_prng_generator;

	logic clk;
	logic arst_n;

	tsp_if #(.W(33)) in_if ();
	tsp_if #(.W(64)) out_if ();

	table_shuffle_prng_generator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if.sink),
		.out_ch (out_if.source)
	);

	// predictor state
	logic [31:0] perm_q [256];
	logic [31:0] mix_q [256];
	logic [31:0] cons_q;
	logic [7:0]  step_q;
	logic [31:0] run_q;
	logic [7:0]  low_q;

	tsp_pkg::result_t expected_words[$];
	int          n_errors;
	int          n_checked;
	int          n_seeds;
	int          n_folds;
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[table_shuffle_prng_generator] ERROR");
		$finish;
	end

	function automatic logic [31:0] rot_left(logic [31:0] v, logic [31:0] amt);
		logic [4:0] s;
		s = amt[4:0];
		if (s == 5'd0) return v;
		return (v << s) | (v >> (6'd32 - s));
	endfunction

	function automatic logic [31:0] splitmix_hash(logic [31:0] v);
		v = v ^ (v >> 16);
		v = v * tsp_pkg::HashMulA;
		v = v ^ (v >> 15);
		v = v * tsp_pkg::HashMulB;
		v = v ^ (v >> 16);
		return v;
	endfunction

	task automatic predict_seed(logic [31:0] key);
		logic [31:0] h;
		logic [31:0] k;
		h = splitmix_hash(key);
		for (int j = 0; j < 256; j++) begin
			k = j;
			perm_q[j] = rot_left(k * tsp_pkg::PermMul + tsp_pkg::PermMul * h, h ^ k);
			mix_q[j]  = rot_left(k * tsp_pkg::MixMul + tsp_pkg::MixMul * h, h ^ k);
		end
		cons_q = key;
		step_q = tsp_pkg::CycleLen;
		run_q = key;
		low_q = '0;
		n_seeds++;
	endtask

	task automatic predict_word(output tsp_pkg::result_t r);
		logic [31:0] o, b, c, d, tmp, acc, folded;
		logic [7:0]  i, di;
		i = step_q;
		d = {24'd0, low_q};
		o = (mix_q[8'(i + 8'd6)] << 6) ^ (mix_q[8'(i + 8'd7)] << 7);
		run_q = (d ^ o) ^ (cons_q + run_q);
		b = (cons_q + run_q) ^ (o + d);
		c = rot_left((run_q >> 13) ^ run_q, b);
		r.random_word = c;
		r.cycle_constant = cons_q;
		di = c[7:0];
		low_q = di;
		tmp = perm_q[i];
		perm_q[i] = perm_q[di];
		perm_q[di] = tmp;
		if (i <= 8'd1) begin
			for (int j = 0; j < 256; j++) mix_q[j] ^= perm_q[j];
			folded = '0;
			for (int e = 0; e < 8; e++) begin
				acc = '0;
				for (int j = 0; j < 32; j++) acc ^= mix_q[e * 32 + j];
				folded ^= acc << e;
			end
			cons_q = folded;
			step_q = tsp_pkg::CycleLen;
			run_q = folded;
			low_q = '0;
			n_folds++;
		end else begin
			step_q = i - 8'd1;
		end
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %08h want %08h (word %0d)", what, got, want, n_checked);
		n_errors++;
	endtask

	// sends one word; valid stays high across back-to-back words
	task automatic send_word(logic op, logic [31:0] key);
		tsp_pkg::result_t r;
		if (!no_idle && $urandom_range(99) < 28) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.data <= {key, op};
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		if (op == tsp_pkg::OpSeed) predict_seed(key);
		else begin
			predict_word(r);
			expected_words.push_back(r);
		end
	endtask

	task automatic gen_words(int n);
		repeat (n) send_word(tsp_pkg::OpGen, $urandom);
	endtask

	task automatic test_seed_extremes();
		send_word(tsp_pkg::OpSeed, 32'h0000_0000);
		gen_words(4);
		send_word(tsp_pkg::OpSeed, 32'hffff_ffff);
		send_word(tsp_pkg::OpGen, 32'h0000_0000);
		send_word(tsp_pkg::OpGen, 32'hffff_ffff);
		gen_words(3);
		send_word(tsp_pkg::OpSeed, 32'haaaa_5555);
		send_word(tsp_pkg::OpSeed, 32'h5555_aaaa);
		gen_words(4);
	endtask

	// runs through two end-of-cycle folds
	task automatic test_cycle_rollover();
		send_word(tsp_pkg::OpSeed, $urandom);
		no_idle = 1'b1;
		gen_words(200);
		no_idle = 1'b0;
		gen_words(320);
	endtask

	task automatic test_drain_pause();
		send_word(tsp_pkg::OpSeed, $urandom);
		gen_words(10);
		in_if.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		gen_words(10);
	endtask

	task automatic test_random_mix();
		repeat (280) begin
			if ($urandom_range(99) < 4) send_word(tsp_pkg::OpSeed, $urandom);
			else send_word(tsp_pkg::OpGen, $urandom);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			out_if.ready <= no_idle || ($urandom_range(99) >= 28);
		end
	end

	always @(posedge clk) begin
		tsp_pkg::result_t got, want;
		if (arst_n && out_if.valid && out_if.ready) begin
			got = out_if.data;
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected random_word", got.random_word, 32'd0);
			end else begin
				want = expected_words.pop_front();
				if (got.random_word !== want.random_word)
					report_mismatch("random_word", got.random_word, want.random_word);
				if (got.cycle_constant !== want.cycle_constant)
					report_mismatch("cycle_constant", got.cycle_constant, want.cycle_constant);
			end
			n_checked++;
		end
	end

	initial begin
		n_errors = 0;
		n_checked = 0;
		n_seeds = 0;
		n_folds = 0;
		no_idle = 1'b0;
		arst_n <= 1'b0;
		in_if.valid <= 1'b0;
		in_if.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_seed_extremes();
		test_cycle_rollover();
		test_drain_pause();
		test_random_mix();

		in_if.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (1200) @(posedge clk);
		if (expected_words.size() != 0) begin
			$display("%0d expected words never arrived", expected_words.size());
			n_errors++;
		end
		$display("covered %0d seeds, %0d table folds, %0d checked result words",
			n_seeds, n_folds, n_checked);
		if (n_errors == 0) begin
			$display("[table_shuffle_prng_generator] OK");
		end else begin
			$display("[table_shuffle_prng_generator] ERROR");
		end
		$finish;
	end
endmodule
